>>> rtl/core/cea_pkg.sv
// shared types and constants for the chain extent averager
`default_nettype none
package cea_pkg;
    localparam int BOX_W = 31;
    localparam int POS_W = 32;
    localparam int UNW_W = 48;
    localparam int SUM_W = 64;
    localparam int AVG_W = 40;
    localparam int CNT_W = 17;
    localparam int FRM_W = 32;
    localparam int NUM_AXES = 3;
    localparam int AXIS_W = 2;
    localparam logic [CNT_W-1:0] MAX_CHAINS = 17'd65536;
    localparam int IDX_W = 2;
    localparam logic [IDX_W-1:0] REG_BOX_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_BOX_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_BOX_Z = 2'd2;
    localparam int QDEPTH = 2;

    // one frame-end request handed from front to back
    typedef struct packed {
        logic [NUM_AXES-1:0][SUM_W-1:0] sum;
        logic [CNT_W-1:0]               count;
        logic [FRM_W-1:0]               frame;
    } frame_req_t;

    typedef struct packed {
        logic [NUM_AXES-1:0][AVG_W-1:0] avg;
        logic [CNT_W-1:0]               count;
        logic [FRM_W-1:0]               frame;
    } frame_res_t;
endpackage
`default_nettype wire

>>> rtl/core/cea_front.sv
// front part: bond unwrapping, extent tracking and per-frame sums
`default_nettype none
module cea_front (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     in_valid,
    output logic                                          in_ready,
    input  wire logic [cea_pkg::NUM_AXES-1:0][cea_pkg::POS_W-1:0] pos,
    input  wire logic                                     chain_start,
    input  wire logic                                     frame_end,
    input  wire logic [cea_pkg::NUM_AXES-1:0][cea_pkg::BOX_W-1:0] box_len,
    output logic                                          req_valid,
    input  wire logic                                     req_ready,
    output cea_pkg::frame_req_t                           req
);
    import cea_pkg::*;

    logic signed [POS_W-1:0] prev_reg [NUM_AXES];
    logic signed [UNW_W-1:0] unw_reg  [NUM_AXES];
    logic signed [UNW_W-1:0] min_reg  [NUM_AXES];
    logic signed [UNW_W-1:0] max_reg  [NUM_AXES];
    logic [SUM_W-1:0]        sum_reg  [NUM_AXES];
    logic [CNT_W-1:0]        cnt_reg;
    logic [FRM_W-1:0]        frm_reg;
    logic                    open_reg;
    logic                    pend_reg;

    logic signed [UNW_W-1:0] unw_next [NUM_AXES];
    logic signed [UNW_W-1:0] min_next [NUM_AXES];
    logic signed [UNW_W-1:0] max_next [NUM_AXES];
    logic [SUM_W-1:0]        sum_close [NUM_AXES];
    logic [CNT_W-1:0]        cnt_close;
    logic                    do_close;
    logic                    acc;

    // a frame end may only be taken when the queue has room; the cycle after it
    // closes the last chain and hands the request over
    assign in_ready = req_ready && !pend_reg;
    assign acc = in_valid && in_ready;

    always_comb begin
        logic signed [POS_W+1:0] d;
        logic signed [POS_W+1:0] d2;
        logic signed [POS_W+1:0] l;
        logic signed [UNW_W+1:0] u;
        logic [SUM_W:0]          s;
        for (int a = 0; a < NUM_AXES; a++) begin
            l  = {3'b000, box_len[a]};
            d  = {{2{pos[a][POS_W-1]}}, pos[a]} - {{2{prev_reg[a][POS_W-1]}}, prev_reg[a]};
            d2 = d <<< 1;
            if (d2 > l) begin
                d = d - l;
            end else if (d2 < -l) begin
                d = d + l;
            end
            u = {{2{unw_reg[a][UNW_W-1]}}, unw_reg[a]}
                + {{(UNW_W-POS_W){d[POS_W+1]}}, d};
            if (u > $signed({2'b00, 1'b0, {(UNW_W-1){1'b1}}})) begin
                unw_next[a] = {1'b0, {(UNW_W-1){1'b1}}};
            end else if (u < $signed({2'b11, 1'b1, {(UNW_W-1){1'b0}}})) begin
                unw_next[a] = {1'b1, {(UNW_W-1){1'b0}}};
            end else begin
                unw_next[a] = u[UNW_W-1:0];
            end
            min_next[a] = (unw_next[a] < min_reg[a]) ? unw_next[a] : min_reg[a];
            max_next[a] = (unw_next[a] > max_reg[a]) ? unw_next[a] : max_reg[a];
            s = {1'b0, sum_reg[a]} + {{(SUM_W-UNW_W+1){1'b0}},
                (max_reg[a] - min_reg[a])};
            sum_close[a] = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
        end
    end

    assign do_close  = open_reg && (cnt_reg < MAX_CHAINS);
    assign cnt_close = cnt_reg + CNT_W'(1);

    // frame-end request built from the registered state after the frame-end monomer
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            req.sum[a] = do_close ? sum_close[a] : sum_reg[a];
        end
        req.count = do_close ? cnt_close : cnt_reg;
        req.frame = frm_reg;
    end

    assign req_valid = pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                prev_reg[a] <= '0;
                unw_reg[a]  <= '0;
                min_reg[a]  <= '0;
                max_reg[a]  <= '0;
                sum_reg[a]  <= '0;
            end
            cnt_reg  <= '0;
            frm_reg  <= '0;
            open_reg <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= acc && frame_end;
            if (acc) begin
                if (chain_start) begin
                    for (int a = 0; a < NUM_AXES; a++) begin
                        prev_reg[a] <= pos[a];
                        unw_reg[a]  <= {{(UNW_W-POS_W){pos[a][POS_W-1]}}, pos[a]};
                        min_reg[a]  <= {{(UNW_W-POS_W){pos[a][POS_W-1]}}, pos[a]};
                        max_reg[a]  <= {{(UNW_W-POS_W){pos[a][POS_W-1]}}, pos[a]};
                        if (do_close) sum_reg[a] <= sum_close[a];
                    end
                    if (do_close) cnt_reg <= cnt_close;
                    open_reg <= 1'b1;
                end else if (open_reg) begin
                    for (int a = 0; a < NUM_AXES; a++) begin
                        prev_reg[a] <= pos[a];
                        unw_reg[a]  <= unw_next[a];
                        min_reg[a]  <= min_next[a];
                        max_reg[a]  <= max_next[a];
                    end
                end
            end else if (pend_reg) begin
                for (int a = 0; a < NUM_AXES; a++) sum_reg[a] <= '0;
                cnt_reg  <= '0;
                open_reg <= 1'b0;
                frm_reg  <= frm_reg + FRM_W'(1);
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= MAX_CHAINS) else $error("chain count beyond limit");
    assert property (@(posedge aclk) disable iff (!aresetn)
        req_valid |-> req.count <= MAX_CHAINS) else $error("bad request count");
    assert property (@(posedge aclk) disable iff (!aresetn)
        req_valid |-> req_ready) else $error("request without queue room");
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |=> (cnt_reg == '0 && !open_reg))
        else $error("frame state not cleared");
    assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg |-> (min_reg[0] <= max_reg[0])) else $error("x range inverted");
endmodule
`default_nettype wire

>>> rtl/core/cea_queue.sv
// short request queue between the front and the divider
`default_nettype none
module cea_queue (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                wr_valid,
    output logic                     wr_ready,
    input  wire cea_pkg::frame_req_t wr_data,
    output logic                     rd_valid,
    input  wire logic                rd_ready,
    output cea_pkg::frame_req_t      rd_data
);
    import cea_pkg::*;

    frame_req_t mem_reg [QDEPTH];
    logic [0:0] wp_reg;
    logic [0:0] rp_reg;
    logic [1:0] fill_reg;

    assign wr_ready = fill_reg != 2'(QDEPTH);
    assign rd_valid = fill_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr_valid && wr_ready) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            fill_reg <= '0;
        end else begin
            if (wr_valid && wr_ready) wp_reg <= wp_reg + 1'b1;
            if (rd_valid && rd_ready) rp_reg <= rp_reg + 1'b1;
            fill_reg <= fill_reg + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= 2'(QDEPTH)) else $error("queue overfilled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == 2'd0) |-> (wp_reg == rp_reg)) else $error("pointer mismatch");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == 2'(QDEPTH)) |-> (wp_reg == rp_reg)) else $error("pointer mismatch full");
endmodule
`default_nettype wire

>>> rtl/core/cea_divider.sv
// back part: restoring divider for the per-axis averages, one bit a cycle
`default_nettype none
module cea_divider (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire cea_pkg::frame_req_t req,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output cea_pkg::frame_res_t      res
);
    import cea_pkg::*;

    typedef enum logic [1:0] {IDLE, DIVIDE, NEXT_AXIS, DONE} state_t;

    state_t                  state_reg;
    logic [SUM_W-1:0]        quo_reg;
    logic [CNT_W:0]          rem_reg;
    logic [6:0]              bit_reg;
    logic [AXIS_W-1:0]       axis_reg;
    frame_req_t              req_reg;
    frame_res_t              res_reg;

    logic [CNT_W:0]          trial;
    logic [CNT_W:0]          shifted;

    assign req_ready = state_reg == IDLE;
    assign res_valid = state_reg == DONE;
    assign res       = res_reg;
    assign shifted   = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
    assign trial     = shifted - {1'b0, req_reg.count};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            bit_reg   <= '0;
            axis_reg  <= '0;
        end else begin
            unique case (state_reg)
                IDLE: begin
                    if (req_valid) begin
                        req_reg   <= req;
                        res_reg.count <= req.count;
                        res_reg.frame <= req.frame;
                        axis_reg  <= '0;
                        quo_reg   <= req.sum[0];
                        rem_reg   <= '0;
                        bit_reg   <= 7'(SUM_W);
                        state_reg <= DIVIDE;
                    end
                end
                DIVIDE: begin
                    if (!trial[CNT_W]) begin
                        rem_reg <= trial;
                        quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= shifted;
                        quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
                    end
                    bit_reg <= bit_reg - 7'd1;
                    if (bit_reg == 7'd1) state_reg <= NEXT_AXIS;
                end
                NEXT_AXIS: begin
                    if (req_reg.count == '0) begin
                        res_reg.avg[axis_reg] <= '0;
                    end else if (quo_reg[SUM_W-1:AVG_W] != '0) begin
                        res_reg.avg[axis_reg] <= {AVG_W{1'b1}};
                    end else begin
                        res_reg.avg[axis_reg] <= quo_reg[AVG_W-1:0];
                    end
                    if (axis_reg == AXIS_W'(NUM_AXES - 1)) begin
                        state_reg <= DONE;
                    end else begin
                        axis_reg  <= axis_reg + AXIS_W'(1);
                        quo_reg   <= req_reg.sum[axis_reg + AXIS_W'(1)];
                        rem_reg   <= '0;
                        bit_reg   <= 7'(SUM_W);
                        state_reg <= DIVIDE;
                    end
                end
                DONE: begin
                    if (res_ready) state_reg <= IDLE;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == DIVIDE) |-> (bit_reg != 7'd0)) else $error("bit count ran out");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == DIVIDE) |-> (rem_reg < {1'b0, req_reg.count} || req_reg.count == '0))
        else $error("remainder too large");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> res_valid) else $error("result dropped");
endmodule
`default_nettype wire

>>> rtl/core/chain_extent_averager.sv
// top level of the chain extent averager
`default_nettype none
// Monomers are taken one per cycle: the front unwraps each bond and tracks
// per-axis extents as each monomer is taken. After a frame-end monomer,
// s_tready is low in the following cycle while the last chain is closed and
// the frame-end request is formed. The request goes through a two-entry queue
// to a shared bit-serial divider, which takes no new request until its result
// is taken; monomers keep streaming while it works, and s_tready also falls
// while two frame ends are already queued.
module chain_extent_averager (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [95:0]  s_tdata,  // pos_x, pos_y, pos_z
    input  wire logic         s_tlast,  // frame_end
    input  wire logic         s_tuser,  // chain_start
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [175:0]      m_tdata,  // avg_extent_x/y/z, chain_total, frame_index, pad
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [30:0]  cfg_data
);
    import cea_pkg::*;

    logic [NUM_AXES-1:0][BOX_W-1:0] box_reg;
    logic [NUM_AXES-1:0][POS_W-1:0] pos;
    frame_req_t f_req, q_req;
    frame_res_t res;
    logic f_valid, f_ready, q_valid, q_ready;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < NUM_AXES; a++) box_reg[a] <= 31'd655360;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_BOX_X: box_reg[0] <= cfg_data;
                REG_BOX_Y: box_reg[1] <= cfg_data;
                REG_BOX_Z: box_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign pos[0] = s_tdata[31:0];
    assign pos[1] = s_tdata[63:32];
    assign pos[2] = s_tdata[95:64];

    cea_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .pos, .chain_start(s_tuser), .frame_end(s_tlast),
        .box_len(box_reg),
        .req_valid(f_valid), .req_ready(f_ready), .req(f_req)
    );

    cea_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_req),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_req)
    );

    cea_divider u_div (
        .aclk, .aresetn,
        .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
        .res_valid(m_tvalid), .res_ready(m_tready), .res
    );

    assign m_tdata = {7'd0, res.frame, res.count, res.avg[2], res.avg[1], res.avg[0]};
endmodule
`default_nettype wire
